FILE: rtl/gtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_pkg
// Shared constants, types and field arithmetic for the GF(2^m) trace unit.
// ----------------------------------------------------------------------------
package gtu_pkg;

	localparam int MAX_DEG = 16;
	localparam int MIN_DEG = 3;
	localparam int DEG_W   = 5;
	localparam int EXP_W   = 32;
	localparam int IDX_W   = $clog2(MAX_DEG);
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// fold cells needed to reduce a full exponent modulo 2^m-1
	localparam int FOLD_N  = (EXP_W + MIN_DEG - 1) / MIN_DEG;
	// power chain: per exponent bit, one square step per coefficient plus a round cell
	localparam int PW_N    = MAX_DEG * (MAX_DEG + 1);
	// trace chain: one accumulate cell per conjugate, a squaring between neighbors
	localparam int TR_N    = MAX_DEG + (MAX_DEG - 1) * MAX_DEG;

	// register indexes on the configuration port
	localparam logic REG_DEGREE = 1'b0;
	localparam logic REG_POLY   = 1'b1;

	typedef struct packed {
		logic [DEG_W-1:0]   deg;
		logic [MAX_DEG-1:0] mask;
		logic [MAX_DEG-1:0] hi;
		logic [MAX_DEG-1:0] poly;
	} cfg_t;

	typedef struct packed {
		logic               func;
		logic               ok;
		logic [MAX_DEG-1:0] v;
		logic [EXP_W-1:0]   rem;
		logic [MAX_DEG-1:0] acc;
	} fold_t;

	typedef struct packed {
		logic               func;
		logic               ok;
		logic [MAX_DEG-1:0] v;
		logic [MAX_DEG-1:0] e;
		logic [MAX_DEG-1:0] a;
		logic [MAX_DEG-1:0] acc;
		logic [MAX_DEG-1:0] sum;
	} st_t;

	function automatic logic [MAX_DEG-1:0] mul_alpha(input logic [MAX_DEG-1:0] v,
			input cfg_t c);
		logic [MAX_DEG-1:0] r;
		logic               top;
		top = |(v & c.hi);
		r   = (v << 1) & c.mask;
		if (top) begin
			r = r ^ c.poly;
		end
		return r;
	endfunction

endpackage

FILE: rtl/gtu_fold_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_fold_cell
// Adds the next m-bit chunk of the exponent into an end-around-carry sum.
// ----------------------------------------------------------------------------
module gtu_fold_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  gtu_pkg::cfg_t cfg,
	input  logic          in_valid,
	input  gtu_pkg::fold_t d,
	output logic          out_valid,
	output gtu_pkg::fold_t q
);

	logic                        vld_q;
	gtu_pkg::fold_t              d_q;
	gtu_pkg::fold_t              nxt;
	logic [gtu_pkg::MAX_DEG-1:0] chunk;
	logic [gtu_pkg::MAX_DEG:0]   s;

	always_comb begin
		nxt   = d;
		chunk = d.rem[gtu_pkg::MAX_DEG-1:0] & cfg.mask;
		s     = {1'b0, d.acc} + {1'b0, chunk};
		// wrap the carry out of bit m back into bit 0
		if (|(s & ~{1'b0, cfg.mask})) begin
			nxt.acc = (s[gtu_pkg::MAX_DEG-1:0] & cfg.mask) + gtu_pkg::MAX_DEG'(1);
		end else begin
			nxt.acc = s[gtu_pkg::MAX_DEG-1:0];
		end
		nxt.rem = d.rem >> cfg.deg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign out_valid = vld_q;
	assign q         = d_q;

endmodule

FILE: rtl/gtu_sq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_sq_cell
// One shift-and-add step of a squaring a*a in GF(2)[x] mod the field polynomial.
// ----------------------------------------------------------------------------
module gtu_sq_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gtu_pkg::cfg_t             cfg,
	input  logic [gtu_pkg::IDX_W-1:0] idx,
	input  logic                      in_valid,
	input  gtu_pkg::st_t              d,
	output logic                      out_valid,
	output gtu_pkg::st_t              q
);

	logic         vld_q;
	gtu_pkg::st_t d_q;
	gtu_pkg::st_t nxt;

	always_comb begin
		nxt     = d;
		nxt.acc = gtu_pkg::mul_alpha(d.acc, cfg) ^ (d.a[idx] ? d.a : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign out_valid = vld_q;
	assign q         = d_q;

endmodule

FILE: rtl/gtu_pow_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_pow_cell
// Closes one square-and-multiply round and loads its result for the next squaring.
// ----------------------------------------------------------------------------
module gtu_pow_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gtu_pkg::cfg_t             cfg,
	input  logic [gtu_pkg::IDX_W-1:0] idx,
	input  logic                      in_valid,
	input  gtu_pkg::st_t              d,
	output logic                      out_valid,
	output gtu_pkg::st_t              q
);

	logic                        vld_q;
	gtu_pkg::st_t                d_q;
	gtu_pkg::st_t                nxt;
	logic [gtu_pkg::MAX_DEG-1:0] r;

	always_comb begin
		nxt = d;
		r   = d.acc;
		if (d.e[idx]) begin
			r = gtu_pkg::mul_alpha(r, cfg);
		end
		nxt.a   = r;
		nxt.acc = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign out_valid = vld_q;
	assign q         = d_q;

endmodule

FILE: rtl/gtu_tr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_tr_cell
// Adds conjugate j into the trace sum and loads it for the next squaring.
// ----------------------------------------------------------------------------
module gtu_tr_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gtu_pkg::cfg_t             cfg,
	input  logic [gtu_pkg::DEG_W-1:0] idx,
	input  logic                      in_valid,
	input  gtu_pkg::st_t              d,
	output logic                      out_valid,
	output gtu_pkg::st_t              q
);

	logic         vld_q;
	gtu_pkg::st_t d_q;
	gtu_pkg::st_t nxt;

	always_comb begin
		nxt = d;
		// only the first m conjugates count
		if (idx < cfg.deg) begin
			nxt.sum = d.sum ^ d.acc;
		end
		nxt.a   = d.acc;
		nxt.acc = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign out_valid = vld_q;
	assign q         = d_q;

endmodule

FILE: rtl/gf2m_trace_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2m_trace_unit
// Absolute trace of alpha^e or of a coefficient vector in GF(2^m).
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------
//  query in  | start && !busy         | func, exponent, element
//  result    | done (one cycle)       | trace_bit, field_ok
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata
//
// A new item is taken every cycle; busy stays low. Each item passes in order
// through the cell chain: exponent folding, square-and-multiply steps, then
// the conjugate sum.
// Reset clears the valid bits of the chain and loads degree 3, poly 3.
// The receiver cannot stall, so the chain never holds.
// ----------------------------------------------------------------------------
module gf2m_trace_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [31:0]                  exponent,
	input  logic [15:0]                  element,
	output logic                         done,
	output logic                         trace_bit,
	output logic                         field_ok,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gtu_pkg::ADDR_W-1:0]   paddr,
	input  logic [gtu_pkg::DATA_W-1:0]   pwdata,
	output logic [gtu_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	logic [gtu_pkg::DEG_W-1:0]   degree_q;
	logic [gtu_pkg::MAX_DEG-1:0] poly_q;
	gtu_pkg::cfg_t               cfg;
	logic [gtu_pkg::MAX_DEG:0]   mask_w;
	logic                        ok;
	logic                        wr;

	gtu_pkg::fold_t fd [gtu_pkg::FOLD_N+1];
	logic           fv [gtu_pkg::FOLD_N+1];
	gtu_pkg::st_t   pd [gtu_pkg::PW_N+1];
	logic           pv [gtu_pkg::PW_N+1];
	gtu_pkg::st_t   td [gtu_pkg::TR_N+1];
	logic           tv [gtu_pkg::TR_N+1];

	// configuration port
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= gtu_pkg::DEG_W'(3);
			poly_q   <= gtu_pkg::MAX_DEG'(3);
		end else if (wr) begin
			case (paddr[2])
				gtu_pkg::REG_DEGREE: degree_q <= pwdata[gtu_pkg::DEG_W-1:0];
				gtu_pkg::REG_POLY:   poly_q   <= pwdata[gtu_pkg::MAX_DEG-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			gtu_pkg::REG_DEGREE: prdata = gtu_pkg::DATA_W'(degree_q);
			gtu_pkg::REG_POLY:   prdata = gtu_pkg::DATA_W'(poly_q);
			default:             prdata = '0;
		endcase
	end

	assign mask_w   = (gtu_pkg::MAX_DEG+1)'(1) << degree_q;
	assign cfg.deg  = degree_q;
	assign cfg.mask = mask_w[gtu_pkg::MAX_DEG-1:0] - gtu_pkg::MAX_DEG'(1);
	assign cfg.hi   = cfg.mask ^ (cfg.mask >> 1);
	assign cfg.poly = poly_q & cfg.mask;

	assign ok   = degree_q[0] && (degree_q >= gtu_pkg::DEG_W'(gtu_pkg::MIN_DEG))
		&& (degree_q <= gtu_pkg::DEG_W'(gtu_pkg::MAX_DEG));
	assign busy = 1'b0;

	// chain entry
	always_comb begin
		fv[0]      = start;
		fd[0].func = func;
		fd[0].ok   = ok;
		fd[0].v    = element & cfg.mask;
		fd[0].rem  = exponent;
		fd[0].acc  = '0;
	end

	for (genvar i = 0; i < gtu_pkg::FOLD_N; i++) begin : g_fold
		gtu_fold_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg),
			.in_valid (fv[i]),
			.d        (fd[i]),
			.out_valid(fv[i+1]),
			.q        (fd[i+1])
		);
	end

	// start power chain at r = 1, exponent fully reduced
	always_comb begin
		pv[0]      = fv[gtu_pkg::FOLD_N];
		pd[0].func = fd[gtu_pkg::FOLD_N].func;
		pd[0].ok   = fd[gtu_pkg::FOLD_N].ok;
		pd[0].v    = fd[gtu_pkg::FOLD_N].v;
		pd[0].e    = (fd[gtu_pkg::FOLD_N].acc == cfg.mask) ? '0 : fd[gtu_pkg::FOLD_N].acc;
		pd[0].a    = gtu_pkg::MAX_DEG'(1);
		pd[0].acc  = '0;
		pd[0].sum  = '0;
	end

	for (genvar p = 0; p < gtu_pkg::PW_N; p++) begin : g_pow
		localparam int K = p % (gtu_pkg::MAX_DEG + 1);
		localparam int R = p / (gtu_pkg::MAX_DEG + 1);
		if (K < gtu_pkg::MAX_DEG) begin : g_sq
			gtu_sq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cfg      (cfg),
				.idx      (gtu_pkg::IDX_W'(gtu_pkg::MAX_DEG - 1 - K)),
				.in_valid (pv[p]),
				.d        (pd[p]),
				.out_valid(pv[p+1]),
				.q        (pd[p+1])
			);
		end else begin : g_rnd
			gtu_pow_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cfg      (cfg),
				.idx      (gtu_pkg::IDX_W'(gtu_pkg::MAX_DEG - 1 - R)),
				.in_valid (pv[p]),
				.d        (pd[p]),
				.out_valid(pv[p+1]),
				.q        (pd[p+1])
			);
		end
	end

	// pick the element to trace: the power or the given vector
	always_comb begin
		tv[0]     = pv[gtu_pkg::PW_N];
		td[0]     = pd[gtu_pkg::PW_N];
		td[0].acc = pd[gtu_pkg::PW_N].func ? pd[gtu_pkg::PW_N].v : pd[gtu_pkg::PW_N].a;
		td[0].sum = '0;
	end

	for (genvar p = 0; p < gtu_pkg::TR_N; p++) begin : g_tr
		localparam int Q = p % (gtu_pkg::MAX_DEG + 1);
		localparam int J = p / (gtu_pkg::MAX_DEG + 1);
		if (Q == 0) begin : g_acc
			gtu_tr_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cfg      (cfg),
				.idx      (gtu_pkg::DEG_W'(J)),
				.in_valid (tv[p]),
				.d        (td[p]),
				.out_valid(tv[p+1]),
				.q        (td[p+1])
			);
		end else begin : g_sq
			gtu_sq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cfg      (cfg),
				.idx      (gtu_pkg::IDX_W'(gtu_pkg::MAX_DEG - Q)),
				.in_valid (tv[p]),
				.d        (td[p]),
				.out_valid(tv[p+1]),
				.q        (td[p+1])
			);
		end
	end

	assign done      = tv[gtu_pkg::TR_N];
	assign trace_bit = td[gtu_pkg::TR_N].ok & td[gtu_pkg::TR_N].sum[0];
	assign field_ok  = td[gtu_pkg::TR_N].ok;

endmodule
